// File: sv/elias_delta_encoder_top_macros.svh
// Assertion macros used by the Elias delta encoder packer
`ifndef ELIAS_DELTA_ENCODER_TOP_MACROS_SVH
`define ELIAS_DELTA_ENCODER_TOP_MACROS_SVH

// checked outside reset only
`define EDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define EDE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/ede_pkg.sv
// Types and constants for the Elias delta encoder
package ede_pkg;

  localparam int WORD_W        = 32;          // packed word width
  localparam int WIN_W         = 3 * WORD_W;  // pending word plus two words of new code
  localparam int CODE_W        = 42;          // longest code for a 32-bit value
  localparam int RES_DEPTH_DEF = 4;           // result queue depth, at least 3

  typedef enum logic {
    ACT_ENCODE = 1'b0,
    ACT_FLUSH  = 1'b1
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [WORD_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0]   packed_word;
    logic [5:0]          word_bits;
    logic                value_error;
    logic                last;
  } out_item_t;

  // results of one item: count is 0, 1 or 2, word0 goes out first
  typedef struct packed {
    logic [1:0]          count;
    out_item_t           word0;
    out_item_t           word1;
  } pack_res_t;

endpackage

// File: sv/ede_pack.sv
// Code builder and bit packer with the pending partial word
`include "elias_delta_encoder_top_macros.svh"

module ede_pack (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  ede_pkg::in_item_t item,
  output ede_pkg::pack_res_t res
);
  import ede_pkg::*;

  localparam logic [6:0] TOT_ONE = 7'(WORD_W);
  localparam logic [6:0] TOT_TWO = 7'(2 * WORD_W);

  logic [WORD_W-1:0] partial_word, partial_word_next;
  logic [4:0]        partial_count, partial_count_next;

  logic [5:0]        k;
  logic [2:0]        p;
  logic [5:0]        len;
  logic [6:0]        total;
  logic [6:0]        sh;
  logic [CODE_W-1:0] code;
  logic [WIN_W-1:0]  win;
  logic [WIN_W-1:0]  strm;

  function automatic logic [5:0] bit_len(input logic [WORD_W-1:0] x);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (x[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

  always_comb begin
    k = bit_len(item.value);
    if (k[5])      p = 3'd6;
    else if (k[4]) p = 3'd5;
    else if (k[3]) p = 3'd4;
    else if (k[2]) p = 3'd3;
    else if (k[1]) p = 3'd2;
    else           p = 3'd1;
    len = {2'b00, p, 1'b0} + k - 6'd2;
    // k << (k-1) | low bits of v equals v + ((k-1) << (k-1))
    code = CODE_W'(item.value) + (CODE_W'(k - 6'd1) << (k - 6'd1));
    sh = 7'(WIN_W) - {1'b0, len} - {2'b00, partial_count};
    win = WIN_W'(code) << sh;
    strm = {partial_word, {(2 * WORD_W){1'b0}}} | win;
    total = {1'b0, len} + {2'b00, partial_count};

    res = '0;
    partial_word_next = partial_word;
    partial_count_next = partial_count;

    if (item.action == ACT_FLUSH) begin
      res.count = 2'd1;
      res.word0.packed_word = partial_word;
      res.word0.word_bits = {1'b0, partial_count};
      res.word0.last = 1'b1;
      partial_word_next = '0;
      partial_count_next = '0;
    end else if (item.value == '0) begin
      res.count = 2'd1;
      res.word0.value_error = 1'b1;
      res.word0.last = 1'b1;
    end else if (total < TOT_ONE) begin
      partial_word_next = strm[WIN_W-1 -: WORD_W];
      partial_count_next = total[4:0];
    end else if (total >= TOT_TWO) begin
      res.count = 2'd2;
      res.word0.packed_word = strm[WIN_W-1 -: WORD_W];
      res.word0.word_bits = 6'(WORD_W);
      res.word1.packed_word = strm[2*WORD_W-1 -: WORD_W];
      res.word1.word_bits = 6'(WORD_W);
      res.word1.last = 1'b1;
      partial_word_next = strm[WORD_W-1:0];
      partial_count_next = 5'(total - TOT_TWO);
    end else begin
      res.count = 2'd1;
      res.word0.packed_word = strm[WIN_W-1 -: WORD_W];
      res.word0.word_bits = 6'(WORD_W);
      res.word0.last = 1'b1;
      partial_word_next = strm[2*WORD_W-1 -: WORD_W];
      partial_count_next = 5'(total - TOT_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word <= '0;
      partial_count <= '0;
    end else if (fire) begin
      partial_word <= partial_word_next;
      partial_count <= partial_count_next;
    end
  end

  // registers are unknown until the first reset edge
  `EDE_ASSERT_ALWAYS(a_pad_zero,
    rst || (partial_word & ({WORD_W{1'b1}} >> partial_count)) == '0,
    "pending word has bits set past its count")
  `EDE_ASSERT(a_flush_clears,
    fire && item.action == ACT_FLUSH |=> partial_count == '0 && partial_word == '0,
    "flush did not clear pending bits")
  `EDE_ASSERT(a_zero_keeps,
    fire && item.action == ACT_ENCODE && item.value == '0
      |=> $stable(partial_word) && $stable(partial_count),
    "rejected zero changed the stream")
  `EDE_ASSERT(a_quiet_grows,
    fire && res.count == 2'd0 |=> partial_count > $past(partial_count),
    "encode without output did not add bits")

endmodule

// File: sv/ede_res_fifo.sv
// Result queue taking up to two words per cycle and giving one when not stalled
module ede_res_fifo #(
  parameter int DEPTH = ede_pkg::RES_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ede_pkg::pack_res_t  wr,
  output logic                space_ok,
  output logic                res_valid,
  input  logic                res_stall,
  output ede_pkg::out_item_t  res_data
);
  import ede_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t         mem [DEPTH];
  logic [PW-1:0]     wr_ptr, wr_ptr_next, wr_ptr1;
  logic [PW-1:0]     rd_ptr, rd_ptr_next;
  logic [CW-1:0]     count, count_next;
  logic [1:0]        npush;
  logic              pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] x);
    return (x == PW'(DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  assign npush     = push ? wr.count : 2'd0;
  assign pop       = res_valid & ~res_stall;
  assign res_valid = (count != '0);
  assign res_data  = mem[rd_ptr];
  // room for a two-word item, judged on the registered count
  assign space_ok  = (count <= CW'(DEPTH - 2));
  assign wr_ptr1   = ptr_inc(wr_ptr);

  always_comb begin
    case (npush)
      2'd1:    wr_ptr_next = wr_ptr1;
      2'd2:    wr_ptr_next = ptr_inc(wr_ptr1);
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = pop ? ptr_inc(rd_ptr) : rd_ptr;
    count_next = count + CW'(npush) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (npush != 2'd0) mem[wr_ptr] <= wr.word0;
    if (npush == 2'd2) mem[wr_ptr1] <= wr.word1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count <= count_next;
    end
  end

endmodule

// File: sv/elias_delta_encoder_top.sv
// Elias delta encoder: one value per cycle in unless stalled, packed 32-bit
// words out. Each item passes through the item register, the packer and the
// result queue; a second word of the same item leaves after the first.
// Throughput: one item per cycle while the result queue has room for two words;
// results leave at one word per cycle unless stalled, so RES_DEPTH bounds bursts.
// Reset clears the pending bits and empties the queue; no clearing pass.
module elias_delta_encoder_top #(
  parameter int RES_DEPTH = ede_pkg::RES_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  ede_pkg::in_item_t   item_data,
  output logic                res_valid,
  input  logic                res_stall,
  output ede_pkg::out_item_t  res_data
);
  import ede_pkg::*;

  logic       item_full, item_full_next;
  in_item_t   item_reg;
  logic       space_ok;
  logic       advance;
  logic       accept;
  pack_res_t  pack_res;

  assign advance        = item_full & space_ok;
  assign item_stall     = item_full & ~space_ok;
  assign accept         = item_valid & ~item_stall;
  assign item_full_next = accept | (item_full & ~advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else begin
      item_full <= item_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_reg <= item_data;
  end

  ede_pack u_pack (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (item_reg),
    .res  (pack_res)
  );

  ede_res_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .wr        (pack_res),
    .space_ok  (space_ok),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

endmodule

// File: tb/elias_delta_encoder_top_tb.sv
// Self-checking testbench for the Elias delta encoder: directed and random streams
`timescale 1ns / 1ps

module elias_delta_encoder_top_tb;
  import ede_pkg::*;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RAND,
    STALL_EVERY_N,
    STALL_LONG
  } stall_mode_t;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_item_t  item_data;
  logic      res_valid;
  logic      res_stall;
  out_item_t res_data;

  // expected output words, oldest first
  out_item_t   expected_words[$];
  logic [31:0] pend_word = '0;
  int          pend_cnt = 0;
  int          mismatch_cnt = 0;
  bit          idle_on = 1'b1;
  bit          held = 1'b0;
  int          burst_left = 0;

  elias_delta_encoder_top u_top (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_data  (item_data),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int bit_len(logic [31:0] x);
    int n;
    n = 0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = i + 1;
    end
    return n;
  endfunction

  // append the delta code of one item to the pending stream, queue any full words
  function automatic void encode_delta(in_item_t it);
    int          k;
    int          p;
    int          len;
    int          total;
    int          rem;
    logic [63:0] code;
    logic [63:0] aligned;
    logic [63:0] rest;
    logic [31:0] w0;
    if (it.action == ACT_FLUSH) begin
      expected_words.push_back(out_item_t'{pend_word, 6'(pend_cnt), 1'b0, 1'b1});
      pend_word = '0;
      pend_cnt  = 0;
      return;
    end
    if (it.value == '0) begin
      expected_words.push_back(out_item_t'{32'd0, 6'd0, 1'b1, 1'b1});
      return;
    end
    k       = bit_len(it.value);
    p       = bit_len(32'(k));
    code    = (64'(k) << (k - 1)) | (64'(it.value) & ((64'd1 << (k - 1)) - 64'd1));
    len     = 2 * p - 2 + k;
    aligned = code << (64 - len);
    w0      = pend_word | 32'(aligned >> (WORD_W + pend_cnt));
    rest    = aligned << (WORD_W - pend_cnt);
    total   = pend_cnt + len;
    if (total < WORD_W) begin
      pend_word = w0;
      pend_cnt  = total;
      return;
    end
    rem = total - WORD_W;
    if (rem >= WORD_W) begin
      expected_words.push_back(out_item_t'{w0, 6'(WORD_W), 1'b0, 1'b0});
      expected_words.push_back(out_item_t'{rest[63:32], 6'(WORD_W), 1'b0, 1'b1});
      rem  = rem - WORD_W;
      rest = rest << 32;
    end else begin
      expected_words.push_back(out_item_t'{w0, 6'(WORD_W), 1'b0, 1'b1});
    end
    pend_word = rest[63:32];
    pend_cnt  = rem;
  endfunction

  // result check first, then prediction of the item taken at the same edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, res_data);
          mismatch_cnt++;
        end else begin
          want = expected_words.pop_front();
          if (res_data.packed_word !== want.packed_word) begin
            $display("%0t: packed_word expected %h actual %h", $time,
                     want.packed_word, res_data.packed_word);
            mismatch_cnt++;
          end
          if (res_data.word_bits !== want.word_bits) begin
            $display("%0t: word_bits expected %0d actual %0d", $time,
                     want.word_bits, res_data.word_bits);
            mismatch_cnt++;
          end
          if (res_data.value_error !== want.value_error) begin
            $display("%0t: value_error expected %b actual %b", $time,
                     want.value_error, res_data.value_error);
            mismatch_cnt++;
          end
          if (res_data.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, res_data.last);
            mismatch_cnt++;
          end
        end
      end
      if (item_valid && !item_stall) encode_delta(item_data);
    end
  end

  // receiver stall pattern, re-chosen every stretch
  initial begin : res_stall_gen
    stall_mode_t mode;
    int          stall_left;
    int          cyc;
    res_stall  = 1'b0;
    mode       = STALL_NONE;
    stall_left = 0;
    cyc        = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (stall_left == 0) begin
        mode       = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      if (!idle_on) begin
        res_stall <= 1'b0;
      end else begin
        case (mode)
          STALL_NONE:    res_stall <= 1'b0;
          STALL_RAND:    res_stall <= ($urandom_range(0, 2) == 0);
          STALL_EVERY_N: res_stall <= (cyc % 3 == 0);
          default:       res_stall <= ((stall_left % 12) < 7);
        endcase
      end
    end
  end

  // one transfer on the item channel, then maybe a gap
  task automatic send_item(input action_t act, input logic [31:0] val);
    int gap;
    item_valid <= 1'b1;
    item_data  <= in_item_t'{act, val};
    held = 1'b1;
    do @(posedge clk); while (item_stall);
    if (idle_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 40);
        gap        = $urandom_range(1, 6);
        item_valid <= 1'b0;
        held = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic in_item_t rand_item();
    int          sel;
    int          k;
    logic [63:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 8) return in_item_t'{ACT_FLUSH, 32'($urandom)};
    if (sel < 13) return in_item_t'{ACT_ENCODE, 32'd0};
    if (sel < 20) return in_item_t'{ACT_ENCODE, 32'($urandom)};
    // pick the bit length first so short and long codes mix evenly
    k = $urandom_range(1, 32);
    v = (64'($urandom) & ((64'd1 << k) - 64'd1)) | (64'd1 << (k - 1));
    return in_item_t'{ACT_ENCODE, v[31:0]};
  endfunction

  task automatic test_directed_edges();
    send_item(ACT_FLUSH,  32'hA5A5_5A5A);  // flush, nothing pending
    send_item(ACT_ENCODE, 32'h0000_0000);  // zero value rejected
    send_item(ACT_ENCODE, 32'h0000_0001);
    send_item(ACT_FLUSH,  32'h0000_0000);
    send_item(ACT_ENCODE, 32'hFFFF_FFFF);  // longest code
    send_item(ACT_ENCODE, 32'h8000_0000);
    send_item(ACT_ENCODE, 32'hFFFF_FFFF);
    send_item(ACT_ENCODE, 32'hFFFF_FFFF);  // two words from one code
    send_item(ACT_ENCODE, 32'h0000_0000);  // zero with bits pending
    send_item(ACT_FLUSH,  32'hFFFF_FFFF);
    send_item(ACT_ENCODE, 32'h0000_8000);  // 24 bits
    send_item(ACT_ENCODE, 32'h0000_0008);  // lands exactly on a word
    send_item(ACT_ENCODE, 32'hFFFF_FFFF);  // 42 bits
    send_item(ACT_ENCODE, 32'h0000_4000);  // 21 bits: leaves 31 pending
    send_item(ACT_ENCODE, 32'h0040_0000);  // 31-bit code on a nearly full word
    send_item(ACT_FLUSH,  32'h5A5A_A5A5);
    send_item(ACT_ENCODE, 32'h0000_0002);
    send_item(ACT_ENCODE, 32'h0000_0003);
    send_item(ACT_ENCODE, 32'h7FFF_FFFF);
  endtask

  task automatic test_random_stream();
    in_item_t it;
    for (int i = 0; i < 750; i++) begin
      it = rand_item();
      send_item(it.action, it.value);
    end
  endtask

  // no gaps and no result stalls: input backs up on the result queue
  task automatic test_back_to_back();
    in_item_t it;
    idle_on = 1'b0;
    for (int i = 0; i < 330; i++) begin
      it = rand_item();
      send_item(it.action, it.value);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item_data  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_random_stream();
    test_back_to_back();
    test_random_stream();
    if (held) item_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
